### hw/rtl/gibi_pkg.sv
// gibi_pkg: shared widths, codes and the result word type for the gf2 basis filter
// no dependencies

package gibi_pkg;

    localparam int VECTOR_WIDTH_DEF = 64;
    localparam int ROW_W            = 64;
    localparam int CFG_W            = 7;
    localparam int RANK_W           = 7;
    localparam int PIVOT_W          = 6;
    localparam int CFG_IDX_W        = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 1'b1;

    localparam logic [CFG_W-1:0] COLS_RST   = 7'd64;
    localparam logic [CFG_W-1:0] TARGET_RST = 7'd64;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef struct packed {
        logic                accepted;
        logic [RANK_W-1:0]   basis_size;
        logic                basis_complete;
        logic [PIVOT_W-1:0]  pivot_column;
    } t_result;

endpackage

### hw/rtl/gibi_if.sv
// gibi_in_if / gibi_out_if: valid-ready channels for input and result words
// depends on gibi_pkg

interface gibi_in_if import gibi_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             op;
    logic [ROW_W-1:0] row_bits;

    modport source (output valid, output op, output row_bits, input ready);
    modport sink   (input valid, input op, input row_bits, output ready);
endinterface

interface gibi_out_if import gibi_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               accepted;
    logic [RANK_W-1:0]  basis_size;
    logic               basis_complete;
    logic [PIVOT_W-1:0] pivot_column;

    modport source (output valid, output accepted, output basis_size,
                    output basis_complete, output pivot_column, input ready);
    modport sink   (input valid, input accepted, input basis_size,
                    input basis_complete, input pivot_column, output ready);
endinterface

### hw/rtl/gf2_incremental_basis_insert_top.sv
// gf2_incremental_basis_insert_top: gf2 linear independence filter, top level
// depends on gibi_pkg, gibi_if, gibi_engine and gibi_out_reg
//
// Each input word either clears the basis or offers a 0/1 vector; the vector is
// reduced against the stored echelon rows one pivot column per cycle, reading one
// row a cycle from the basis memory, and kept at its lowest set column if it stays
// nonzero. An insert walks every column, from the lowest up, before its result is
// ready; a clear, or an insert against a complete basis, skips the walk. One result
// word per input word; the next input word is taken while a result still waits in
// the output register. Configuration must be written only while no word is in
// flight; the block itself does not enforce it.

module gf2_incremental_basis_insert_top import gibi_pkg::*; #(
    parameter int VECTOR_WIDTH = VECTOR_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    gibi_in_if.sink              i_in,
    gibi_out_if.source           o_out,
    input  logic                 i_cfg_wen,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    logic [CFG_W-1:0] r_cols;
    logic [CFG_W-1:0] r_target;
    t_result          res;
    logic             res_valid;
    logic             res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols   <= COLS_RST;
            r_target <= TARGET_RST;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                CFG_COLS:   r_cols   <= i_cfg_wdata;
                CFG_TARGET: r_target <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    gibi_engine #(
        .VECTOR_WIDTH (VECTOR_WIDTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cols      (r_cols),
        .i_target    (r_target),
        .o_res       (res),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready)
    );

    gibi_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res       (res),
        .i_res_valid (res_valid),
        .o_res_ready (res_ready),
        .o_out       (o_out)
    );

endmodule

### hw/rtl/gibi_engine.sv
// gibi_engine: basis row memory, pivot valid bits, rank and the column scan sequencer
// depends on gibi_pkg and gibi_in_if

module gibi_engine import gibi_pkg::*; #(
    parameter int VECTOR_WIDTH = VECTOR_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    gibi_in_if.sink          i_in,
    input  logic [CFG_W-1:0] i_cols,
    input  logic [CFG_W-1:0] i_target,
    output t_result          o_res,
    output logic             o_res_valid,
    input  logic             i_res_ready
);

    localparam int COL_W = $clog2(VECTOR_WIDTH);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} t_state;

    t_state                  r_state;
    logic [VECTOR_WIDTH-1:0] r_vec;
    logic [COL_W:0]          r_col;
    logic                    r_ck_valid;
    logic [COL_W-1:0]        r_ck_col;
    logic                    r_found;
    logic [COL_W-1:0]        r_pivot;
    logic                    r_clear;
    logic [VECTOR_WIDTH-1:0] r_pv;
    logic [RANK_W-1:0]       r_rank;

    logic [VECTOR_WIDTH-1:0] r_mem [VECTOR_WIDTH];
    logic [VECTOR_WIDTH-1:0] r_rdata;

    logic [VECTOR_WIDTH-1:0] mask;
    logic [VECTOR_WIDTH-1:0] n_vec;
    logic [COL_W-1:0]        rd_addr;
    logic                    in_fire;
    logic                    res_fire;
    logic                    mem_we;
    logic [RANK_W-1:0]       rank_after;

    always_comb begin
        for (int i = 0; i < VECTOR_WIDTH; i++) begin
            mask[i] = (i_cols > CFG_W'(i));
        end
    end

    // reduce against the pivot row read in the previous cycle
    always_comb begin
        n_vec = r_vec;
        if (r_ck_valid && r_vec[r_ck_col] && r_pv[r_ck_col]) begin
            n_vec = r_vec ^ r_rdata;
        end
    end

    assign rd_addr     = r_col[COL_W-1:0];
    assign i_in.ready  = (r_state == S_IDLE);
    assign in_fire     = i_in.valid && i_in.ready;
    assign o_res_valid = (r_state == S_DONE);
    assign res_fire    = o_res_valid && i_res_ready;
    assign mem_we      = res_fire && r_found;
    assign rank_after  = r_clear ? '0 : (r_found ? RANK_W'(r_rank + 7'd1) : r_rank);

    always_comb begin
        o_res.accepted       = r_found;
        o_res.basis_size     = rank_after;
        o_res.basis_complete = (rank_after >= i_target);
        o_res.pivot_column   = r_found ? PIVOT_W'(r_pivot) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_pivot] <= r_vec & mask;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ck_valid <= 1'b0;
            r_pv       <= '0;
            r_rank     <= '0;
            r_found    <= 1'b0;
            r_clear    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_ck_valid <= 1'b0;
                    if (in_fire) begin
                        r_found <= 1'b0;
                        r_pivot <= '0;
                        r_col   <= '0;
                        r_vec   <= i_in.row_bits[VECTOR_WIDTH-1:0] & mask;
                        if (i_in.op == OP_CLEAR) begin
                            r_clear <= 1'b1;
                            r_state <= S_DONE;
                        end else if (r_rank < i_target) begin
                            r_clear <= 1'b0;
                            r_state <= S_SCAN;
                        end else begin
                            r_clear <= 1'b0;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_col < (COL_W+1)'(VECTOR_WIDTH)) begin
                        r_col <= r_col + 1'b1;
                    end
                    r_ck_valid <= (r_col < (COL_W+1)'(VECTOR_WIDTH));
                    r_ck_col   <= rd_addr;
                    r_vec      <= n_vec;
                    if (r_ck_valid) begin
                        if (n_vec[r_ck_col] && mask[r_ck_col] && !r_found) begin
                            r_found <= 1'b1;
                            r_pivot <= r_ck_col;
                        end
                        if (r_ck_col == COL_W'(VECTOR_WIDTH - 1)) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    r_ck_valid <= 1'b0;
                    if (res_fire) begin
                        r_rank  <= rank_after;
                        if (r_clear) begin
                            r_pv <= '0;
                        end else if (r_found) begin
                            r_pv[r_pivot] <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_rank_matches_pivots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_pv) == int'(r_rank))
        else $error("rank differs from number of valid pivots");

    a_rank_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_rank) <= VECTOR_WIDTH)
        else $error("rank above vector width");

    a_new_pivot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_found) |-> !r_pv[r_pivot])
        else $error("pivot column already occupied");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state != S_IDLE))
        else $error("engine idle right after taking a word");
`endif

endmodule

### hw/rtl/gibi_out_reg.sv
// gibi_out_reg: output register that holds a finished result word until taken
// depends on gibi_pkg and gibi_out_if

module gibi_out_reg import gibi_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_result     i_res,
    input  logic        i_res_valid,
    output logic        o_res_ready,
    gibi_out_if.source  o_out
);

    logic    r_full;
    t_result r_word;

    assign o_res_ready          = !r_full || o_out.ready;
    assign o_out.valid          = r_full;
    assign o_out.accepted       = r_word.accepted;
    assign o_out.basis_size     = r_word.basis_size;
    assign o_out.basis_complete = r_word.basis_complete;
    assign o_out.pivot_column   = r_word.pivot_column;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (i_res_valid && o_res_ready) begin
            r_full <= 1'b1;
        end else if (o_out.ready) begin
            r_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid && o_res_ready) begin
            r_word <= i_res;
        end
    end

endmodule

### dv/tb.sv
// tb: self-checking bench for gf2_incremental_basis_insert_top, directed then random words
// depends on gibi_pkg, gibi_if and the top level; predicts every result word in step

module tb;
    import gibi_pkg::*;

    localparam int CYCLE_LIMIT  = 800000;
    localparam int RANDOM_WORDS = 650;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wen;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_wdata;

    gibi_in_if  in_ch ();
    gibi_out_if out_ch ();

    gf2_incremental_basis_insert_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // shadow of the basis filter
    logic [ROW_W-1:0] shadow_rows [ROW_W];
    logic [ROW_W-1:0] shadow_pivots;
    logic [RANK_W-1:0] shadow_rank;
    logic [CFG_W-1:0] shadow_cols;
    logic [CFG_W-1:0] shadow_target;

    t_result pending_outcomes [$];
    int      errors;
    int      words_sent;
    int      cycles;
    bit      bursty;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [ROW_W-1:0] column_window();
        int n;
        n = (shadow_cols > ROW_W) ? ROW_W : int'(shadow_cols);
        if (n >= ROW_W)
            return '1;
        return (64'd1 << n) - 64'd1;
    endfunction

    function automatic t_result filter_vector(logic op, logic [ROW_W-1:0] row);
        t_result          res;
        logic [ROW_W-1:0] win;
        logic [ROW_W-1:0] v;
        int               piv;
        res = '0;
        if (op == OP_CLEAR) begin
            shadow_pivots = '0;
            shadow_rank   = '0;
        end else if (shadow_rank < shadow_target) begin
            win = column_window();
            v   = row & win;
            for (int c = 0; c < ROW_W; c++)
                if (v[c] && shadow_pivots[c])
                    v = v ^ shadow_rows[c];
            v = v & win;
            if (v != '0) begin
                piv = 0;
                for (int c = ROW_W - 1; c >= 0; c--)
                    if (v[c])
                        piv = c;
                shadow_rows[piv]   = v;
                shadow_pivots[piv] = 1'b1;
                shadow_rank        = shadow_rank + 1'b1;
                res.accepted       = 1'b1;
                res.pivot_column   = PIVOT_W'(piv);
            end
        end
        res.basis_size     = shadow_rank;
        res.basis_complete = (shadow_rank >= shadow_target);
        return res;
    endfunction

    function automatic int pick_pause();
        int r;
        if (!bursty)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report(string field, int want, int got);
        $display("mismatch on %s: expected %0d, got %0d (time %0t)", field, want, got, $time);
        errors++;
    endtask

    task automatic send_word(logic op, logic [ROW_W-1:0] row);
        int      gap;
        t_result outcome;
        gap = pick_pause();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.op       <= op;
        in_ch.row_bits <= row;
        do @(posedge i_clk); while (!in_ch.ready);
        outcome = filter_vector(op, row);
        pending_outcomes = {pending_outcomes, outcome};
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic insert_row(logic [ROW_W-1:0] row);
        send_word(OP_INSERT, row);
    endtask

    task automatic clear_basis();
        send_word(OP_CLEAR, {$urandom, $urandom});
    endtask

    task automatic drain_words();
        in_ch.valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        drain_words();
        i_cfg_wen   <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_wen   <= 1'b0;
        if (idx == CFG_COLS)
            shadow_cols = value;
        else
            shadow_target = value;
    endtask

    // result word checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_outcomes.size() == 0) begin
                report("words outstanding", 0, 1);
            end else begin
                want = pending_outcomes.pop_front();
                if (out_ch.accepted !== want.accepted)
                    report("accepted", want.accepted, out_ch.accepted);
                if (out_ch.basis_size !== want.basis_size)
                    report("basis_size", want.basis_size, out_ch.basis_size);
                if (out_ch.basis_complete !== want.basis_complete)
                    report("basis_complete", want.basis_complete, out_ch.basis_complete);
                if (out_ch.pivot_column !== want.pivot_column)
                    report("pivot_column", want.pivot_column, out_ch.pivot_column);
            end
        end
    end

    // result side back-pressure
    initial begin
        int hold;
        int r;
        hold = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                out_ch.ready <= 1'b0;
                hold--;
            end else if (!bursty) begin
                out_ch.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    out_ch.ready <= 1'b1;
                end else begin
                    out_ch.ready <= 1'b0;
                    hold = (r < 94) ? $urandom_range(0, 3) : $urandom_range(10, 40);
                end
            end
        end
    end

    task automatic test_default_columns();
        bursty = 1'b0;
        insert_row('0);
        insert_row('1);
        insert_row(64'h8000_0000_0000_0000);
        insert_row('1);
        insert_row(64'h3);
        insert_row(64'h8000_0000_0000_0001);
        clear_basis();
        insert_row(64'h5555_5555_5555_5554);
        insert_row(64'hAAAA_AAAA_AAAA_AAAA);
    endtask

    task automatic test_target_rank();
        bursty = 1'b1;
        program_reg(CFG_TARGET, 7'd2);
        insert_row(64'h10);
        insert_row(64'h20);
        insert_row(64'h40);
        clear_basis();
        program_reg(CFG_TARGET, 7'd0);
        clear_basis();
        insert_row(64'h1);
        program_reg(CFG_TARGET, 7'd127);
        insert_row(64'h1);
    endtask

    task automatic test_column_mask();
        program_reg(CFG_COLS, 7'd1);
        clear_basis();
        insert_row(64'hFFFF_FFFF_FFFF_FFFE);
        insert_row('1);
        program_reg(CFG_COLS, 7'd0);
        insert_row('1);
        program_reg(CFG_COLS, 7'd100);
        insert_row(64'h8000_0000_0000_0000);
        // narrow the window with a wide row already stored
        program_reg(CFG_COLS, 7'd64);
        clear_basis();
        insert_row(64'h8000_0000_0000_0001);
        program_reg(CFG_COLS, 7'd8);
        insert_row(64'h3);
        insert_row(64'hFF00);
    endtask

    function automatic logic [CFG_W-1:0] pick_setting();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)  return 7'd1;
        if (r < 12) return 7'd0;
        if (r < 17) return 7'($urandom_range(65, 127));
        if (r < 30) return 7'd64;
        if (r < 65) return 7'($urandom_range(2, 16));
        return 7'($urandom_range(17, 63));
    endfunction

    function automatic logic [ROW_W-1:0] pick_vector();
        logic [ROW_W-1:0] v;
        int               r;
        int               k;
        r = $urandom_range(0, 99);
        v = {$urandom, $urandom};
        if (r < 25) begin
        end else if (r < 45) begin
            v = v & column_window();
        end else if (r < 58) begin
            v = 64'd1 << $urandom_range(0, ROW_W - 1);
        end else if (r < 80) begin
            // combination of stored rows, usually dependent
            v = v & ~column_window();
            for (int c = 0; c < ROW_W; c++)
                if (shadow_pivots[c] && $urandom_range(0, 1))
                    v = v ^ shadow_rows[c];
            if ($urandom_range(0, 3) == 0)
                v[$urandom_range(0, ROW_W - 1)] ^= 1'b1;
        end else if (r < 92) begin
            v = '0;
            k = $urandom_range(2, 4);
            repeat (k) v[$urandom_range(0, ROW_W - 1)] = 1'b1;
        end else begin
            v = ($urandom_range(0, 1) != 0) ? '1 : '0;
        end
        return v;
    endfunction

    task automatic test_random_traffic();
        int goal;
        int n;
        goal = words_sent + RANDOM_WORDS;
        while (words_sent < goal) begin
            program_reg(CFG_COLS, pick_setting());
            program_reg(CFG_TARGET, pick_setting());
            bursty = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1) != 0)
                clear_basis();
            n = $urandom_range(30, 70);
            repeat (n) begin
                if ($urandom_range(0, 99) < 4)
                    clear_basis();
                else
                    insert_row(pick_vector());
            end
        end
    endtask

    initial begin
        errors        = 0;
        words_sent    = 0;
        cycles        = 0;
        bursty        = 1'b0;
        shadow_pivots = '0;
        shadow_rank   = '0;
        shadow_cols   = COLS_RST;
        shadow_target = TARGET_RST;
        for (int c = 0; c < ROW_W; c++)
            shadow_rows[c] = '0;
        i_rst_n        = 1'b0;
        i_cfg_wen      = 1'b0;
        i_cfg_idx      = CFG_COLS;
        i_cfg_wdata    = '0;
        in_ch.valid    = 1'b0;
        in_ch.op       = OP_INSERT;
        in_ch.row_bits = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_default_columns();
        test_target_rank();
        test_column_mask();
        test_random_traffic();

        drain_words();
        repeat (80) @(posedge i_clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
